// ===== hw/rtl/ccsm_pkg.sv =====
// Types and constants shared by the character-class sequence matcher.
// Request and result payloads, function codes and controller/datapath links.
// No dependencies.
package ccsm_pkg;

  // Widths fixed by the request and result formats
  localparam int RULE_CNT_W = 5;
  localparam int CONSUMED_W = 16;

  // Request function codes
  localparam logic [1:0] FUNC_RANGE = 2'd0;
  localparam logic [1:0] FUNC_RULE  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_CHAR  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        rule_slot;
    logic [1:0]        range_slot;
    logic signed [7:0] range_low;
    logic signed [7:0] range_high;
    logic              negate;
    logic              and_mode;
    logic [2:0]        range_count;
    logic              repeat_req;
    logic signed [7:0] char_value;
    logic              last_char;
  } in_item_t;

  typedef struct packed {
    logic                  matched;
    logic [CONSUMED_W-1:0] consumed;
  } out_item_t;

  // One stored range
  typedef struct packed {
    logic signed [7:0] lo;
    logic signed [7:0] hi;
    logic              neg;
    logic              and_m;
  } range_ent_t;

  // One stored rule header
  typedef struct packed {
    logic [2:0] cnt;
    logic       rep;
  } rule_hdr_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_range;
    logic wr_rule;
    logic start;
    logic take;
    logic clr_k;
    logic step_k;
    logic adv;
    logic consume;
    logic load_out;
    logic ok;
  } ccsm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic n_zero;
    logic cur_done;
    logic k_done;
    logic flag;
    logic rep;
    logic post_ok;
    logic last;
    logic out_free;
  } ccsm_sts_t;

endpackage

// ===== hw/rtl/ccsm_dpath.sv =====
// Datapath of the sequence matcher: rule and range memories, cursor,
// range walk, character count and the result register. Uses ccsm_pkg.
module ccsm_dpath #(
  parameter int MAX_RULES       = 16,
  parameter int RANGES_PER_RULE = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ccsm_pkg::ccsm_cmd_t                 cmd,
  output ccsm_pkg::ccsm_sts_t                 sts,
  input  ccsm_pkg::in_item_t                  in_data,
  input  logic                                cfg_we,
  input  logic [ccsm_pkg::RULE_CNT_W-1:0]     cfg_wdata,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ccsm_pkg::out_item_t                 out_data
);
  import ccsm_pkg::*;

  localparam int DEPTH = MAX_RULES * RANGES_PER_RULE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int HW    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int KW    = $clog2(RANGES_PER_RULE + 1);

  range_ent_t rng_mem [DEPTH];
  rule_hdr_t  hdr_mem [MAX_RULES];
  range_ent_t rng_rd;
  rule_hdr_t  hdr_rd;

  logic [RULE_CNT_W-1:0] rule_count;
  logic [RULE_CNT_W-1:0] n_act;
  logic [RULE_CNT_W-1:0] cursor;
  logic [RULE_CNT_W-1:0] cursor_next;
  logic [KW-1:0]         k;
  logic [KW-1:0]         k_next;
  logic                  flag;
  logic signed [7:0]     char_q;
  logic                  last_q;
  logic [COUNT_BITS-1:0] count;
  logic [32:0]           count_ext;
  logic [CONSUMED_W-1:0] count_sat;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [HW-1:0]         hdr_addr;
  logic                  in_range;
  logic                  hit;

  // Rule count register
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_count <= '0;
    end else if (cfg_we) begin
      rule_count <= cfg_wdata;
    end
  end

  // Clamp the rule count to the table depth
  always_comb begin
    if (int'(rule_count) > MAX_RULES) begin
      n_act = RULE_CNT_W'(MAX_RULES);
    end else begin
      n_act = rule_count;
    end
  end

  // Next cursor and range index, used to address the memories so the registered reads follow cursor and k
  always_comb begin
    if (cmd.start) begin
      cursor_next = '0;
    end else if (cmd.adv) begin
      cursor_next = cursor + 1'b1;
    end else begin
      cursor_next = cursor;
    end
    if (cmd.clr_k) begin
      k_next = '0;
    end else if (cmd.step_k) begin
      k_next = k + 1'b1;
    end else begin
      k_next = k;
    end
  end

  assign rd_addr  = AW'(int'(cursor_next) * RANGES_PER_RULE + int'(k_next));
  assign hdr_addr = HW'(cursor_next);
  assign wr_addr  = AW'(int'(in_data.rule_slot) * RANGES_PER_RULE
                        + int'(in_data.range_slot));

  // Table memories: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.wr_range && int'(in_data.rule_slot) < MAX_RULES
        && int'(in_data.range_slot) < RANGES_PER_RULE) begin
      rng_mem[wr_addr] <= '{lo: in_data.range_low, hi: in_data.range_high,
                            neg: in_data.negate, and_m: in_data.and_mode};
    end
    if (cmd.wr_rule && int'(in_data.rule_slot) < MAX_RULES) begin
      hdr_mem[HW'(in_data.rule_slot)] <= '{cnt: in_data.range_count,
                                          rep: in_data.repeat_req};
    end
    rng_rd <= rng_mem[rd_addr];
    hdr_rd <= hdr_mem[hdr_addr];
  end

  // Range test of the held character
  assign in_range = (char_q >= rng_rd.lo) && (char_q <= rng_rd.hi);
  assign hit      = in_range ^ rng_rd.neg;

  // Walk state: cursor, range index, running flag, count
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      k      <= '0;
      flag   <= 1'b0;
      count  <= '0;
    end else begin
      cursor <= cursor_next;
      k      <= k_next;
      if (cmd.clr_k) begin
        flag <= 1'b0;
      end else if (cmd.step_k) begin
        flag <= rng_rd.and_m ? (flag & hit) : (flag | hit);
      end
      if (cmd.start) begin
        count <= '0;
      end else if (cmd.consume && !(&count)) begin
        count <= count + 1'b1;
      end
    end
  end

  // Hold the character under test
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      char_q <= in_data.char_value;
      last_q <= in_data.last_char;
    end
  end

  // Saturate the count to the result width
  assign count_ext = 33'(count);
  assign count_sat = (count_ext > 33'({CONSUMED_W{1'b1}})) ? {CONSUMED_W{1'b1}}
                                                           : count_ext[CONSUMED_W-1:0];

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= '{matched: cmd.ok, consumed: cmd.ok ? count_sat : '0};
    end
  end

  // Status back to the controller
  always_comb begin
    sts.n_zero   = (n_act == '0);
    sts.cur_done = (cursor >= n_act);
    sts.k_done   = (int'(k) >= int'(hdr_rd.cnt)) || (int'(k) >= RANGES_PER_RULE);
    sts.flag     = flag;
    sts.rep      = hdr_rd.rep;
    sts.post_ok  = ({1'b0, cursor} + 1'b1) >= {1'b0, n_act};
    sts.last     = last_q;
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// ===== hw/rtl/ccsm_ctrl.sv =====
// Controller of the sequence matcher: request decode, range walk sequencing
// and match state. Uses ccsm_pkg; drives ccsm_dpath through commands.
module ccsm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  ccsm_pkg::ccsm_sts_t sts,
  output ccsm_pkg::ccsm_cmd_t cmd
);
  import ccsm_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_POST  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       busy;
  logic       busy_next;
  logic       ok;
  logic       ok_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    busy_next  = busy;
    ok_next    = ok;
    cmd        = '0;
    cmd.ok     = ok;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (func)
            FUNC_RANGE: cmd.wr_range = 1'b1;
            FUNC_RULE:  cmd.wr_rule  = 1'b1;
            FUNC_START: begin
              cmd.start = 1'b1;
              busy_next = 1'b1;
              if (sts.n_zero) begin
                ok_next    = 1'b0;
                state_next = S_DONE;
              end
            end
            FUNC_CHAR: begin
              if (busy) begin
                if (sts.n_zero) begin
                  ok_next    = 1'b0;
                  state_next = S_DONE;
                end else begin
                  cmd.take   = 1'b1;
                  cmd.clr_k  = 1'b1;
                  state_next = S_CHECK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        // rules exhausted: match ends before this character
        if (sts.cur_done) begin
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (!sts.k_done) begin
          cmd.step_k = 1'b1;
        end else if (sts.flag) begin
          cmd.adv     = !sts.rep;
          cmd.consume = 1'b1;
          state_next  = S_POST;
        end else if (!sts.rep) begin
          ok_next    = 1'b0;
          state_next = S_DONE;
        end else begin
          // repeat rule missed: try the same character on the next rule
          cmd.adv    = 1'b1;
          cmd.clr_k  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_POST: begin
        priority if (sts.cur_done) begin
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else if (sts.last) begin
          ok_next    = sts.post_ok;
          state_next = S_DONE;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          busy_next    = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      ok    <= ok_next;
    end
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded while the result register is full");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (!busy && state == S_IDLE))
    else $error("match not closed after its result");
  a_walk_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && !sts.k_done) |=> (state == S_EVAL))
    else $error("range walk left before its last range");
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_RANGE || func == FUNC_RULE)) |=> (state == S_IDLE))
    else $error("table write did not return to idle");
`endif

endmodule

// ===== hw/rtl/char_class_sequence_matcher.sv =====
// Top level of the character-class sequence matcher.
// Joins ccsm_ctrl and ccsm_dpath; uses ccsm_pkg for payload types.
//
//  Channel  Direction  Handshake              Payload
//  in       request    in_valid / in_ready    in_data  (in_item_t)
//  out      result     out_valid / out_ready  out_data (out_item_t)
//  cfg      write      cfg_we                 cfg_wdata (rule count)
//
// Table writes and start are taken in idle; a start on an empty rule set closes the match.
// A character is tried against the rules in turn, walking each rule's ranges,
// capped at RANGES_PER_RULE, one cycle per range of the shared range comparator;
// a repeat miss adds the next rule's walk. A miss, the last character or the end
// of the rule set closes the match and loads its result; with no rules in use a
// character fails without a walk.
// A result waits in the output register; the controller stalls only when a
// second result is due before the first is taken.
// Synchronous reset clears control state; table memories are undefined until written.
module char_class_sequence_matcher #(
  parameter int MAX_RULES       = 16,
  parameter int RANGES_PER_RULE = 4,
  parameter int COUNT_BITS      = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ccsm_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ccsm_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [ccsm_pkg::RULE_CNT_W-1:0] cfg_wdata
);
  import ccsm_pkg::*;

  ccsm_cmd_t cmd;
  ccsm_sts_t sts;

  ccsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (in_data.func),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccsm_dpath #(
    .MAX_RULES       (MAX_RULES),
    .RANGES_PER_RULE (RANGES_PER_RULE),
    .COUNT_BITS      (COUNT_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
